>>> sv/atcpc_pkg.sv
package atcpc_pkg;

  // Character codes used by the prefix and character-class checks
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_T   = 8'h54;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Packet length limit and counter widths
  localparam int unsigned LEN_W = 16;
  localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = 16'hFFFF;
  localparam logic [LEN_W-1:0] RUN_SAT = 16'hFFFF;

  // Reset value of the minimum padded run register
  localparam logic [7:0] MIN_PADDED_RESET = 8'd4;

  // Bit positions in the live-prefix vector
  localparam int unsigned PFX_CRLF   = 0;
  localparam int unsigned PFX_CRCRLF = 1;
  localparam int unsigned PFX_AT     = 2;
  localparam int unsigned PFX_W      = 3;

  // One classification result
  typedef struct packed {
    logic             is_at_command;
    logic             was_padded;
    logic [LEN_W-1:0] command_length;
  } result_t;

  // Printable, CR or LF
  function automatic logic byte_allowed(input logic [7:0] b);
    byte_allowed = (b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_LF || b == CHAR_CR;
  endfunction

endpackage

>>> sv/at_command_packet_classifier.sv
// AT command packet classifier.
// Input channel (in_valid/in_ready): one packet byte per transfer, with
// in_last_byte set on the final byte. Result channel (out_valid/out_ready):
// one result per packet, sent after its final byte; other bytes give none.
// Configuration: cfg_wr_en writes cfg_wr_data to min_padded_chars at the
// clock edge; write it only while no packet is in flight.
// Throughput: one byte per cycle unless a final byte waits for the result
// register. The packet state is updated by a single pass of flag and
// counter logic between the input register and the result register.
// Result path: the transfer of the final byte loads the input register,
// and the result register loads from there once it is free.
// Reset (rst_n low, synchronous): packet state clears, both pipeline
// registers empty, min_padded_chars returns to 4.
// Receiver stall: the result register holds its transfer; bytes that give
// no result keep flowing, and a final byte waits in the input register,
// with in_ready low, until the result register frees.
module at_command_packet_classifier #(
  parameter logic [atcpc_pkg::LEN_W-1:0] MAX_PACKET_BYTES = atcpc_pkg::MAX_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_at_command,
  output logic        out_was_padded,
  output logic [15:0] out_command_length,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0]         min_padded_r;
  logic               s1_valid_r;
  logic [7:0]         s1_data_r;
  logic               s1_last_r;
  logic               out_valid_r;
  atcpc_pkg::result_t out_r;
  atcpc_pkg::result_t result;
  logic               out_free;
  logic               s1_go;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_padded_r <= atcpc_pkg::MIN_PADDED_RESET;
    end else if (cfg_wr_en) begin
      min_padded_r <= cfg_wr_data;
    end
  end

  // Advance the input stage when its byte needs no result slot or one is free
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  atcpc_tracker #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (s1_go),
    .data_byte        (s1_data_r),
    .last_byte        (s1_last_r),
    .min_padded_chars (min_padded_r),
    .result           (result)
  );

  // Result register: load on a final byte, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_at_command  = out_r.is_at_command;
  assign out_was_padded     = out_r.was_padded;
  assign out_command_length = out_r.command_length;

endmodule

>>> sv/atcpc_tracker.sv
module atcpc_tracker #(
  parameter logic [atcpc_pkg::LEN_W-1:0] MAX_PACKET_BYTES = atcpc_pkg::MAX_PACKET_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  input  logic [7:0]                  min_padded_chars,
  output atcpc_pkg::result_t          result
);

  logic [atcpc_pkg::LEN_W-1:0] byte_index_r, byte_index_nxt;
  logic [atcpc_pkg::PFX_W-1:0] prefix_alive_r, prefix_alive_nxt;
  logic                        run_broken_r, run_broken_nxt;
  logic [atcpc_pkg::LEN_W-1:0] run_len_r, run_len_nxt;
  logic                        tail_zero_r, tail_zero_nxt;
  logic                        overflow_r, overflow_nxt;
  logic                        matched;

  // Per-byte update of the packet state
  always_comb begin
    prefix_alive_nxt = prefix_alive_r;
    if (byte_index_r == atcpc_pkg::LEN_W'(0)) begin
      if (data_byte != atcpc_pkg::CHAR_CR) begin
        prefix_alive_nxt[atcpc_pkg::PFX_CRLF]   = 1'b0;
        prefix_alive_nxt[atcpc_pkg::PFX_CRCRLF] = 1'b0;
      end
      if (data_byte != atcpc_pkg::CHAR_A) prefix_alive_nxt[atcpc_pkg::PFX_AT] = 1'b0;
    end else if (byte_index_r == atcpc_pkg::LEN_W'(1)) begin
      if (data_byte != atcpc_pkg::CHAR_LF) prefix_alive_nxt[atcpc_pkg::PFX_CRLF] = 1'b0;
      if (data_byte != atcpc_pkg::CHAR_CR) prefix_alive_nxt[atcpc_pkg::PFX_CRCRLF] = 1'b0;
      if (data_byte != atcpc_pkg::CHAR_T) prefix_alive_nxt[atcpc_pkg::PFX_AT] = 1'b0;
    end else if (byte_index_r == atcpc_pkg::LEN_W'(2)) begin
      if (data_byte != atcpc_pkg::CHAR_LF) prefix_alive_nxt[atcpc_pkg::PFX_CRCRLF] = 1'b0;
    end

    // Grow the leading allowed run until the first disallowed byte
    run_broken_nxt = run_broken_r;
    run_len_nxt    = run_len_r;
    if (!run_broken_r) begin
      if (atcpc_pkg::byte_allowed(data_byte)) begin
        if (run_len_r != atcpc_pkg::RUN_SAT) run_len_nxt = run_len_r + 1'b1;
      end else begin
        run_broken_nxt = 1'b1;
      end
    end
    tail_zero_nxt = tail_zero_r && !(run_broken_nxt && data_byte != atcpc_pkg::CHAR_NUL);

    // Count bytes, flag oversize packets
    overflow_nxt   = overflow_r;
    byte_index_nxt = byte_index_r;
    if (byte_index_r >= MAX_PACKET_BYTES) overflow_nxt = 1'b1;
    else byte_index_nxt = byte_index_r + 1'b1;
  end

  // Classify at the final byte
  always_comb begin
    matched = (prefix_alive_nxt[atcpc_pkg::PFX_CRLF]   && byte_index_nxt >= atcpc_pkg::LEN_W'(2)) ||
              (prefix_alive_nxt[atcpc_pkg::PFX_CRCRLF] && byte_index_nxt >= atcpc_pkg::LEN_W'(3)) ||
              (prefix_alive_nxt[atcpc_pkg::PFX_AT]     && byte_index_nxt >= atcpc_pkg::LEN_W'(2));
    result = '0;
    if (matched && !overflow_nxt) begin
      if (run_broken_nxt) begin
        if (run_len_nxt > {8'd0, min_padded_chars} && tail_zero_nxt) begin
          result.is_at_command  = 1'b1;
          result.was_padded     = 1'b1;
          result.command_length = run_len_nxt;
        end
      end else begin
        result.is_at_command  = 1'b1;
        result.command_length = byte_index_nxt;
      end
    end
  end

  // Hold state between bytes, clear it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      byte_index_r   <= '0;
      prefix_alive_r <= '1;
      run_broken_r   <= 1'b0;
      run_len_r      <= '0;
      tail_zero_r    <= 1'b1;
      overflow_r     <= 1'b0;
    end else if (step) begin
      byte_index_r   <= byte_index_nxt;
      prefix_alive_r <= prefix_alive_nxt;
      run_broken_r   <= run_broken_nxt;
      run_len_r      <= run_len_nxt;
      tail_zero_r    <= tail_zero_nxt;
      overflow_r     <= overflow_nxt;
    end
  end

endmodule

>>> sv/atcpc_checker.sv
module atcpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_at_command,
  input logic        out_was_padded,
  input logic [15:0] out_command_length
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_at_command) &&
      $stable(out_was_padded) && $stable(out_command_length))
    else $error("result changed while stalled");

  // Rejected packets report all zero
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_at_command |-> !out_was_padded && out_command_length == 16'd0)
    else $error("rejected packet carries padding or length");

  // Padded accept keeps at least one character
  a_padded_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_padded |-> out_is_at_command && out_command_length != 16'd0)
    else $error("padded result without command or length");

  // Unpadded accept covers at least a two-byte prefix
  a_unpadded_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_at_command && !out_was_padded |-> out_command_length >= 16'd2)
    else $error("unpadded command shorter than its prefix");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind at_command_packet_classifier atcpc_checker u_atcpc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_is_at_command  (out_is_at_command),
  .out_was_padded     (out_was_padded),
  .out_command_length (out_command_length)
);

>>> bench/tb.sv
module tb;
  import atcpc_pkg::*;

  // One byte transfer waiting to be offered
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } feed_item_t;

  // How a generated packet starts
  typedef enum int {
    LEAD_AT,
    LEAD_CRLF,
    LEAD_CRCRLF,
    LEAD_A_ONLY,
    LEAD_CR_ONLY,
    LEAD_NONE
  } lead_t;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_PERCENT = 9;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_at_command;
  logic        out_was_padded;
  logic [15:0] out_command_length;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;

  // Stimulus and expectations
  feed_item_t  byte_feed[$];
  result_t     expected_verdicts[$];
  logic [7:0]  pkt_bytes[$];
  feed_item_t  next_item;
  result_t     due;
  int unsigned fed_bytes = 0;
  int unsigned errors = 0;
  logic        steady = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  logic [7:0]  rnd_min;

  // Shadow of the classifier: register and per-packet state
  logic [7:0]       min_pad_model = MIN_PADDED_RESET;
  logic [LEN_W-1:0] seen_count = '0;
  logic [PFX_W-1:0] live_pfx = '1;
  logic             run_broken = 1'b0;
  logic [LEN_W-1:0] text_run = '0;
  logic             tail_zero = 1'b1;
  logic             too_long = 1'b0;
  int unsigned      packets_seen = 0;
  int unsigned      accepts_seen = 0;
  int unsigned      padded_seen = 0;

  at_command_packet_classifier dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_at_command (out_is_at_command),
    .out_was_padded    (out_was_padded),
    .out_command_length(out_command_length),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  function automatic logic is_text_char(input logic [7:0] b);
    return (b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_CR || b == CHAR_LF;
  endfunction

  // Advance the shadow state by one byte; queue a verdict on the final byte
  task automatic classify_byte(input logic [7:0] b, input logic last);
    result_t r;
    logic    matched;
    begin
      case (seen_count)
        16'd0: begin
          if (b != CHAR_CR) begin
            live_pfx[PFX_CRLF] = 1'b0;
            live_pfx[PFX_CRCRLF] = 1'b0;
          end
          if (b != CHAR_A) live_pfx[PFX_AT] = 1'b0;
        end
        16'd1: begin
          if (b != CHAR_LF) live_pfx[PFX_CRLF] = 1'b0;
          if (b != CHAR_CR) live_pfx[PFX_CRCRLF] = 1'b0;
          if (b != CHAR_T) live_pfx[PFX_AT] = 1'b0;
        end
        16'd2: begin
          if (b != CHAR_LF) live_pfx[PFX_CRCRLF] = 1'b0;
        end
        default: ;
      endcase

      if (!run_broken) begin
        if (is_text_char(b)) begin
          if (text_run != RUN_SAT) text_run = text_run + 1'b1;
        end else begin
          run_broken = 1'b1;
        end
      end
      if (run_broken && b != CHAR_NUL) tail_zero = 1'b0;

      if (seen_count >= MAX_PACKET_BYTES) too_long = 1'b1;
      else seen_count = seen_count + 1'b1;

      if (last) begin
        matched = (live_pfx[PFX_CRLF] && seen_count >= 2) ||
                  (live_pfx[PFX_CRCRLF] && seen_count >= 3) ||
                  (live_pfx[PFX_AT] && seen_count >= 2);
        r = '0;
        if (matched && !too_long) begin
          if (!run_broken) begin
            r.is_at_command = 1'b1;
            r.command_length = seen_count;
          end else if (text_run > min_pad_model && tail_zero) begin
            r.is_at_command = 1'b1;
            r.was_padded = 1'b1;
            r.command_length = text_run;
          end
        end
        expected_verdicts.push_back(r);
        packets_seen++;
        if (r.is_at_command) accepts_seen++;
        if (r.was_padded) padded_seen++;
        seen_count = '0;
        live_pfx = '1;
        run_broken = 1'b0;
        text_run = '0;
        tail_zero = 1'b1;
        too_long = 1'b0;
      end
    end
  endtask

  function automatic logic [7:0] text_char();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return CHAR_CR;
    if (r == 1) return CHAR_LF;
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_text_char(b));
    return b;
  endfunction

  // Move the packet under construction into the feed, flagging its last byte
  task automatic send_packet();
    feed_item_t it;
    begin
      foreach (pkt_bytes[i]) begin
        it.data = pkt_bytes[i];
        it.last = (i == pkt_bytes.size() - 1);
        byte_feed.push_back(it);
      end
      fed_bytes += pkt_bytes.size();
      pkt_bytes.delete();
    end
  endtask

  task automatic add_lead(input lead_t lead);
    case (lead)
      LEAD_AT:      begin pkt_bytes.push_back(CHAR_A); pkt_bytes.push_back(CHAR_T); end
      LEAD_CRLF:    begin pkt_bytes.push_back(CHAR_CR); pkt_bytes.push_back(CHAR_LF); end
      LEAD_CRCRLF: begin
        pkt_bytes.push_back(CHAR_CR);
        pkt_bytes.push_back(CHAR_CR);
        pkt_bytes.push_back(CHAR_LF);
      end
      LEAD_A_ONLY:  begin pkt_bytes.push_back(CHAR_A); pkt_bytes.push_back(text_char()); end
      LEAD_CR_ONLY: begin pkt_bytes.push_back(CHAR_CR); pkt_bytes.push_back(text_char()); end
      default: ;
    endcase
  endtask

  // Pad to a text run at the threshold and one above it, never under the prefix
  task automatic pad_boundary();
    for (int d = 0; d < 2; d++) begin
      add_lead(LEAD_AT);
      while (pkt_bytes.size() < min_pad_model + d) pkt_bytes.push_back(text_char());
      pkt_bytes.push_back(CHAR_NUL);
      send_packet();
    end
  endtask

  // Mostly well-formed packets with random content, the rest noise
  task automatic random_packet();
    int unsigned shape;
    int unsigned run;
    begin
      add_lead(lead_t'($urandom_range(0, 5)));
      shape = $urandom_range(0, 99);
      if (shape < 35) begin
        repeat ($urandom_range(0, 20)) pkt_bytes.push_back(text_char());
      end else if (shape < 70) begin
        if (min_pad_model <= 32) begin
          run = min_pad_model + $urandom_range(0, 4);
          if (run > 0) run = run - 1;
        end else begin
          run = $urandom_range(2, 20);
        end
        while (pkt_bytes.size() < run) pkt_bytes.push_back(text_char());
        repeat ($urandom_range(1, 6)) pkt_bytes.push_back(CHAR_NUL);
        // spoil the padding now and then
        if ($urandom_range(0, 4) == 0) pkt_bytes.push_back(bad_byte());
      end else begin
        repeat ($urandom_range(0, 12)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (pkt_bytes.size() == 0) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      send_packet();
    end
  endtask

  task automatic random_bytes(input int unsigned n);
    int unsigned goal;
    begin
      goal = fed_bytes + n;
      while (fed_bytes < goal) random_packet();
    end
  endtask

  // Wait until every queued byte is sent and every packet has been answered
  task automatic await_drain();
    begin
      do @(negedge clk);
      while (byte_feed.size() != 0 || in_valid || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
  endtask

  task automatic set_min_padded(input logic [7:0] v);
    begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= v;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      min_pad_model = v;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Sender: predict each accepted transfer, then offer the next byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) classify_byte(in_data_byte, in_last_byte);
      if (!in_valid || in_ready) begin
        if (byte_feed.size() != 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          next_item = byte_feed.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_item.data;
          in_last_byte <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(0, 99) >= IDLE_PERCENT;
    end
  end

  // Monitor: compare each result transfer with the oldest verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transfer with no packet outstanding");
        errors++;
      end else begin
        due = expected_verdicts.pop_front();
        if (out_is_at_command !== due.is_at_command) begin
          $error("is_at_command mismatch: expected %0d, got %0d",
                 due.is_at_command, out_is_at_command);
          errors++;
        end
        if (out_was_padded !== due.was_padded) begin
          $error("was_padded mismatch: expected %0d, got %0d",
                 due.was_padded, out_was_padded);
          errors++;
        end
        if (out_command_length !== due.command_length) begin
          $error("command_length mismatch: expected %0d, got %0d",
                 due.command_length, out_command_length);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("at_command_packet_classifier verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: each prefix, short packets, padding at the reset threshold
    pkt_bytes = '{CHAR_A, CHAR_T};                         send_packet();
    pkt_bytes = '{CHAR_CR, CHAR_LF};                       send_packet();
    pkt_bytes = '{CHAR_CR, CHAR_CR, CHAR_LF};              send_packet();
    pkt_bytes = '{CHAR_CR};                                send_packet();
    pkt_bytes = '{CHAR_A, CHAR_T, "1", "2", CHAR_NUL};     send_packet();
    pkt_bytes = '{CHAR_A, CHAR_T, PRINT_LO, PRINT_HI, "3", CHAR_NUL, CHAR_NUL};
    send_packet();
    pkt_bytes = '{CHAR_A, CHAR_T, "x", "y", "z", 8'h80};   send_packet();
    pkt_bytes = '{8'hFF};                                  send_packet();
    random_bytes(100);
    await_drain();

    // Lowest threshold, with no idling on either side
    set_min_padded(8'd0);
    steady = 1'b1;
    pad_boundary();
    random_bytes(100);
    await_drain();
    steady = 1'b0;

    // Highest threshold
    set_min_padded(8'd255);
    pad_boundary();
    random_bytes(50);
    await_drain();

    // Fill the block while the receiver holds off
    set_min_padded(8'd1);
    random_bytes(100);
    hold_go = 1'b1;
    await_drain();

    rnd_min = 8'($urandom_range(2, 40));
    set_min_padded(rnd_min);
    pad_boundary();
    random_bytes(80);
    await_drain();

    $display("Checked %0d packets over %0d bytes: %0d AT commands, %0d of them padded.",
             packets_seen, fed_bytes, accepts_seen, padded_seen);
    $display("Thresholds 4, 0, 255, 1 and %0d; a long receiver hold-off filled the block.",
             rnd_min);
    if (errors == 0) begin
      $display("at_command_packet_classifier verification clean");
    end else begin
      $display("at_command_packet_classifier verification failed");
    end
    $finish;
  end

endmodule
